>>> design/leb_pkg.sv
// ----------------------------------------------------------------------------
// leb_pkg
// Shared types and constants for the console line editor.
// ----------------------------------------------------------------------------
package leb_pkg;

    localparam int LINE_CAPACITY = 256;
    localparam int ADDR_W        = $clog2(LINE_CAPACITY);
    localparam int LEN_W         = 8;
    localparam int CHAR_W        = 8;
    localparam int LIMIT_MAX     = (LINE_CAPACITY - 1 < 255) ? LINE_CAPACITY - 1 : 255;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [0:0]       REG_MAX_LENGTH   = 1'b0;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 8'd255;

    typedef enum logic [2:0] {
        FUNC_TYPE      = 3'd0,
        FUNC_HOME      = 3'd1,
        FUNC_END       = 3'd2,
        FUNC_BACKSPACE = 3'd3,
        FUNC_DELETE    = 3'd4,
        FUNC_LEFT      = 3'd5,
        FUNC_RIGHT     = 3'd6,
        FUNC_READ      = 3'd7
    } func_t;

    typedef struct packed {
        func_t             func;
        logic [CHAR_W-1:0] char_in;
        logic [LEN_W-1:0]  read_index;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic [LEN_W-1:0]  cursor_pos;
        logic [LEN_W-1:0]  line_length;
        logic              rejected;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_GROW,
        ST_GROW_WR,
        ST_SHRINK,
        ST_SHRINK_WR,
        ST_FETCH
    } state_t;

    typedef struct packed {
        logic latch;
        logic j_from_len;
        logic j_from_cur;
        logic j_from_cur1;
        logic j_inc;
        logic j_dec;
        logic rd_grow;
        logic rd_shrink;
        logic rd_index;
        logic wr_grow;
        logic wr_shrink;
        logic wr_char;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        func_t func;
        logic  type_ok;
        logic  bs_ok;
        logic  del_ok;
        logic  rd_in;
        logic  grow_done;
        logic  shrink_done;
        logic  out_free;
    } ctrl_stat_t;

endpackage

>>> design/leb_ctrl.sv
// ----------------------------------------------------------------------------
// leb_ctrl
// Sequencer for the line editor: accepts a request, runs a tail shift or a
// read over the line memory and hands the result to the output register.
// ----------------------------------------------------------------------------
module leb_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  leb_pkg::ctrl_stat_t stat,
    output leb_pkg::ctrl_cmd_t  cmd
);

    leb_pkg::state_t state_reg;
    leb_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= leb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = (state_reg == leb_pkg::ST_IDLE);
        unique case (state_reg)
            leb_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = leb_pkg::ST_EXEC;
                end
            end
            leb_pkg::ST_EXEC: begin
                case (stat.func)
                    leb_pkg::FUNC_TYPE: begin
                        if (stat.type_ok) begin
                            cmd.j_from_len = 1'b1;
                            state_next     = leb_pkg::ST_GROW;
                        end else if (stat.out_free) begin
                            cmd.finish = 1'b1;
                            state_next = leb_pkg::ST_IDLE;
                        end
                    end
                    leb_pkg::FUNC_BACKSPACE: begin
                        if (stat.bs_ok) begin
                            cmd.j_from_cur = 1'b1;
                            state_next     = leb_pkg::ST_SHRINK;
                        end else if (stat.out_free) begin
                            cmd.finish = 1'b1;
                            state_next = leb_pkg::ST_IDLE;
                        end
                    end
                    leb_pkg::FUNC_DELETE: begin
                        if (stat.del_ok) begin
                            cmd.j_from_cur1 = 1'b1;
                            state_next      = leb_pkg::ST_SHRINK;
                        end else if (stat.out_free) begin
                            cmd.finish = 1'b1;
                            state_next = leb_pkg::ST_IDLE;
                        end
                    end
                    leb_pkg::FUNC_READ: begin
                        if (stat.rd_in) begin
                            cmd.rd_index = 1'b1;
                            state_next   = leb_pkg::ST_FETCH;
                        end else if (stat.out_free) begin
                            cmd.finish = 1'b1;
                            state_next = leb_pkg::ST_IDLE;
                        end
                    end
                    default: begin
                        if (stat.out_free) begin
                            cmd.finish = 1'b1;
                            state_next = leb_pkg::ST_IDLE;
                        end
                    end
                endcase
            end
            leb_pkg::ST_GROW: begin
                if (stat.grow_done) begin
                    if (stat.out_free) begin
                        cmd.wr_char = 1'b1;
                        cmd.finish  = 1'b1;
                        state_next  = leb_pkg::ST_IDLE;
                    end
                end else begin
                    cmd.rd_grow = 1'b1;
                    state_next  = leb_pkg::ST_GROW_WR;
                end
            end
            leb_pkg::ST_GROW_WR: begin
                cmd.wr_grow = 1'b1;
                cmd.j_dec   = 1'b1;
                state_next  = leb_pkg::ST_GROW;
            end
            leb_pkg::ST_SHRINK: begin
                if (stat.shrink_done) begin
                    if (stat.out_free) begin
                        cmd.finish = 1'b1;
                        state_next = leb_pkg::ST_IDLE;
                    end
                end else begin
                    cmd.rd_shrink = 1'b1;
                    state_next    = leb_pkg::ST_SHRINK_WR;
                end
            end
            leb_pkg::ST_SHRINK_WR: begin
                cmd.wr_shrink = 1'b1;
                cmd.j_inc     = 1'b1;
                state_next    = leb_pkg::ST_SHRINK;
            end
            leb_pkg::ST_FETCH: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = leb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = leb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/leb_datapath.sv
// ----------------------------------------------------------------------------
// leb_datapath
// Line memory, length, cursor, sweep index, limit register and the
// output register of the line editor.
// ----------------------------------------------------------------------------
module leb_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  leb_pkg::ctrl_cmd_t          cmd,
    output leb_pkg::ctrl_stat_t         stat,
    input  leb_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output leb_pkg::out_item_t          m_data,
    input  logic                        cfg_we,
    input  logic [leb_pkg::LEN_W-1:0]   cfg_wdata,
    output logic [leb_pkg::LEN_W-1:0]   max_length
);

    localparam logic [leb_pkg::LEN_W-1:0] LIMIT_TOP = leb_pkg::LEN_W'(leb_pkg::LIMIT_MAX);
    localparam logic [leb_pkg::LEN_W-1:0] ONE       = leb_pkg::LEN_W'(1);

    logic [leb_pkg::CHAR_W-1:0] line_mem [leb_pkg::LINE_CAPACITY];

    leb_pkg::in_item_t          item_reg;
    leb_pkg::out_item_t         out_reg;
    leb_pkg::out_item_t         out_next;
    logic                       m_valid_reg;
    logic [leb_pkg::LEN_W-1:0]  length_reg;
    logic [leb_pkg::LEN_W-1:0]  length_next;
    logic [leb_pkg::LEN_W-1:0]  cursor_reg;
    logic [leb_pkg::LEN_W-1:0]  cursor_next;
    logic [leb_pkg::LEN_W-1:0]  j_reg;
    logic [leb_pkg::LEN_W-1:0]  j_next;
    logic [leb_pkg::LEN_W-1:0]  max_length_reg;
    logic [leb_pkg::CHAR_W-1:0] rdata_reg;
    logic [leb_pkg::LEN_W-1:0]  limit;
    logic [leb_pkg::ADDR_W-1:0] rd_addr;
    logic [leb_pkg::ADDR_W-1:0] wr_addr;
    logic [leb_pkg::CHAR_W-1:0] wr_data;
    logic                       rd_en;
    logic                       wr_en;

    assign limit = (max_length_reg == '0 || max_length_reg > LIMIT_TOP) ? LIMIT_TOP
                                                                        : max_length_reg;

    always_comb begin
        stat.func        = item_reg.func;
        stat.type_ok     = (length_reg < limit);
        stat.bs_ok       = (cursor_reg != '0);
        stat.del_ok      = (cursor_reg < length_reg);
        stat.rd_in       = (item_reg.read_index < length_reg);
        stat.grow_done   = (j_reg == cursor_reg);
        stat.shrink_done = (j_reg >= length_reg);
        stat.out_free    = !m_valid_reg || m_ready;
    end

    // sweep index
    always_comb begin
        j_next = j_reg;
        if (cmd.j_from_len) begin
            j_next = length_reg;
        end else if (cmd.j_from_cur) begin
            j_next = cursor_reg;
        end else if (cmd.j_from_cur1) begin
            j_next = cursor_reg + ONE;
        end else if (cmd.j_inc) begin
            j_next = j_reg + ONE;
        end else if (cmd.j_dec) begin
            j_next = j_reg - ONE;
        end
    end

    always_ff @(posedge aclk) begin
        j_reg <= j_next;
        if (cmd.latch) begin
            item_reg <= s_data;
        end
    end

    // line memory, one write and one registered read per cycle
    always_comb begin
        rd_en   = cmd.rd_grow | cmd.rd_shrink | cmd.rd_index;
        wr_en   = cmd.wr_grow | cmd.wr_shrink | cmd.wr_char;
        rd_addr = leb_pkg::ADDR_W'(item_reg.read_index);
        if (cmd.rd_grow) begin
            rd_addr = leb_pkg::ADDR_W'(j_reg - ONE);
        end else if (cmd.rd_shrink) begin
            rd_addr = leb_pkg::ADDR_W'(j_reg);
        end
        wr_addr = leb_pkg::ADDR_W'(cursor_reg);
        if (cmd.wr_grow) begin
            wr_addr = leb_pkg::ADDR_W'(j_reg);
        end else if (cmd.wr_shrink) begin
            wr_addr = leb_pkg::ADDR_W'(j_reg - ONE);
        end
        wr_data = cmd.wr_char ? item_reg.char_in : rdata_reg;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= line_mem[rd_addr];
        end
    end

    // end-of-request update
    always_comb begin
        length_next = length_reg;
        cursor_next = cursor_reg;
        case (item_reg.func)
            leb_pkg::FUNC_TYPE: begin
                if (stat.type_ok) begin
                    length_next = length_reg + ONE;
                    cursor_next = cursor_reg + ONE;
                end
            end
            leb_pkg::FUNC_HOME: begin
                cursor_next = '0;
            end
            leb_pkg::FUNC_END: begin
                cursor_next = length_reg;
            end
            leb_pkg::FUNC_BACKSPACE: begin
                if (stat.bs_ok) begin
                    length_next = length_reg - ONE;
                    cursor_next = cursor_reg - ONE;
                end
            end
            leb_pkg::FUNC_DELETE: begin
                if (stat.del_ok) begin
                    length_next = length_reg - ONE;
                end
            end
            leb_pkg::FUNC_LEFT: begin
                if (stat.bs_ok) begin
                    cursor_next = cursor_reg - ONE;
                end
            end
            leb_pkg::FUNC_RIGHT: begin
                if (stat.del_ok) begin
                    cursor_next = cursor_reg + ONE;
                end
            end
            default: begin
            end
        endcase
        out_next.char_out    = (item_reg.func == leb_pkg::FUNC_READ && stat.rd_in) ? rdata_reg
                                                                                     : '0;
        out_next.cursor_pos  = cursor_next;
        out_next.line_length = length_next;
        out_next.rejected    = (item_reg.func == leb_pkg::FUNC_TYPE) && !stat.type_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg     <= '0;
            cursor_reg     <= '0;
            m_valid_reg    <= 1'b0;
            max_length_reg <= leb_pkg::MAX_LENGTH_RESET;
        end else begin
            if (cfg_we) begin
                max_length_reg <= cfg_wdata;
            end
            if (cmd.finish) begin
                length_reg  <= length_next;
                cursor_reg  <= cursor_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_reg <= out_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_data     = out_reg;
    assign max_length = max_length_reg;

endmodule

>>> design/line_edit_buffer.sv
// ----------------------------------------------------------------------------
// line_edit_buffer
// Console line editor: keeps a character line, its length and a cursor,
// and applies one key event per request.
//
//   channel  direction  ports                    payload
//   s_       in         s_valid, s_ready         leb_pkg::in_item_t
//   m_       out        m_valid, m_ready         leb_pkg::out_item_t
//   apb      in/out     psel..pready             max_length at offset 0
//
// Home, end, left, right, reads past the end and edits that change nothing
// finish without touching the line memory; a read in range fetches one
// character; other types, backspaces and deletes move the tail one character
// per read and write of the line memory. A new request is taken the cycle
// after the previous result is loaded, while that result may still wait.
// Reset empties the line and sets max_length to 255; a stalled result holds
// the sequencer at its final step.
// ----------------------------------------------------------------------------
module line_edit_buffer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  leb_pkg::in_item_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output leb_pkg::out_item_t            m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [leb_pkg::PADDR_W-1:0]   paddr,
    input  logic [leb_pkg::PDATA_W-1:0]   pwdata,
    output logic [leb_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    leb_pkg::ctrl_cmd_t         cmd;
    leb_pkg::ctrl_stat_t        stat;
    logic                       cfg_we;
    logic                       reg_hit;
    logic [leb_pkg::LEN_W-1:0]  max_length;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[leb_pkg::PADDR_W-1:2] == leb_pkg::REG_MAX_LENGTH);
    assign cfg_we  = psel & penable & pwrite & pready & reg_hit;
    assign prdata  = reg_hit ? leb_pkg::PDATA_W'(max_length) : '0;

    leb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    leb_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_we     (cfg_we),
        .cfg_wdata  (pwdata[leb_pkg::LEN_W-1:0]),
        .max_length (max_length)
    );

endmodule

>>> design/leb_checker.sv
// ----------------------------------------------------------------------------
// leb_checker
// Port-level checks for the line editor, bound to the top level.
// ----------------------------------------------------------------------------
module leb_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input leb_pkg::out_item_t m_data
);

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while another is in progress");

    a_cursor_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.cursor_pos <= m_data.line_length)
        else $error("cursor beyond end of line");

    a_reject_no_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.rejected |-> m_data.char_out == '0)
        else $error("rejected request returned a character");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

endmodule

bind line_edit_buffer leb_checker u_leb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
